@@ src/ttcb_pkg.sv @@
// Shared types, widths and codes for the text terminal character buffer.
// No dependencies; every other file of the block refers to this package by scoped names.
package ttcb_pkg;

    // Field widths of the command and result beats.
    localparam int FUNC_W     = 3;
    localparam int CHAR_W     = 8;
    localparam int COL_W      = 6;
    localparam int ROW_W      = 5;
    localparam int COLS_CFG_W = 7;
    localparam int ROWS_CFG_W = 6;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    // Default store geometry and register reset values.
    localparam int DEF_MAX_COLS = 64;
    localparam int DEF_MAX_ROWS = 32;
    localparam int COLS_RESET   = 53;
    localparam int ROWS_RESET   = 30;

    // Depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    typedef logic [FUNC_W-1:0]     func_t;
    typedef logic [CHAR_W-1:0]     char_t;
    typedef logic [COL_W-1:0]      col_t;
    typedef logic [ROW_W-1:0]      row_t;
    typedef logic [COLS_CFG_W-1:0] cols_cfg_t;
    typedef logic [ROWS_CFG_W-1:0] rows_cfg_t;

    // Command codes on the func port.
    localparam func_t FUNC_PUT_CHAR   = 3'd0;
    localparam func_t FUNC_WRITE_CHAR = 3'd1;
    localparam func_t FUNC_LOCATE     = 3'd2;
    localparam func_t FUNC_CLEAR      = 3'd3;
    localparam func_t FUNC_READ_CELL  = 3'd4;

    // Register indexes as decoded from paddr[2].
    localparam logic REG_IDX_COLS = 1'b0;
    localparam logic REG_IDX_ROWS = 1'b1;

    // Character codes.
    localparam char_t CODE_LF          = 8'h0a;
    localparam char_t CODE_CR          = 8'h0d;
    localparam char_t CODE_FIRST_PRINT = 8'h20;
    localparam char_t CODE_LAST_PRINT  = 8'h7e;
    localparam char_t CODE_SPACE       = 8'h20;

    // Operation as classified by the front end.
    typedef enum logic [2:0] {
        OP_NOP,
        OP_PRINT,
        OP_CR,
        OP_LF,
        OP_WRITE,
        OP_LOCATE,
        OP_CLEAR,
        OP_READ
    } op_t;

    typedef struct packed {
        op_t   op;
        char_t ch;
        col_t  col;
        row_t  row;
    } cmd_t;

    // Visible area as currently programmed.
    typedef struct packed {
        cols_cfg_t cols;
        rows_cfg_t rows;
    } cfg_t;

    // Register write in progress, with the area that holds after it.
    typedef struct packed {
        logic      we;
        cols_cfg_t cols;
        rows_cfg_t rows;
    } cfg_upd_t;

endpackage

@@ src/ttcb_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// Depends on ttcb_pkg for its default width and depth.
module ttcb_ram #(
    parameter int WIDTH = ttcb_pkg::CHAR_W,
    parameter int DEPTH = ttcb_pkg::DEF_MAX_COLS * ttcb_pkg::DEF_MAX_ROWS,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_reg[waddr] <= wdata;
        end
        rdata_reg <= store_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/ttcb_queue.sv @@
// Short command queue between the front end and the back end.
// Depends on ttcb_pkg for the command type and the queue depth.
module ttcb_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  ttcb_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output ttcb_pkg::cmd_t pop_cmd,
    output logic           empty
);

    localparam int DEPTH = ttcb_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW  = $clog2(DEPTH + 1);
    localparam logic [PW-1:0]   LAST_SLOT = PW'(DEPTH - 1);
    localparam logic [CNTW-1:0] FULL_CNT  = CNTW'(DEPTH);

    ttcb_pkg::cmd_t  slot_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CNTW-1:0] count_reg;
    logic [CNTW-1:0] count_next;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign pop_cmd = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |-> count_reg != FULL_CNT)
        else $error("Command pushed into a full queue.");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("Command popped from an empty queue.");

endmodule

@@ src/ttcb_front.sv @@
// Front end: accepts command beats, checks positions against the visible area and
// classifies each command into an operation for the back end. Depends on ttcb_pkg.
module ttcb_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ttcb_pkg::func_t   func,
    input  ttcb_pkg::char_t   char_code,
    input  ttcb_pkg::col_t    col,
    input  ttcb_pkg::row_t    row,
    input  ttcb_pkg::cfg_t    cfg,
    input  logic              hold,
    input  logic              q_full,
    output logic              push,
    output ttcb_pkg::cmd_t    push_cmd
);

    ttcb_pkg::cmd_t cmd_reg;
    ttcb_pkg::cmd_t cmd_next;
    logic           cmd_valid_reg;
    logic           cmd_valid_next;
    logic           accept;
    logic           in_view;
    logic           printable;

    assign push   = cmd_valid_reg && !q_full;
    assign busy   = hold || (cmd_valid_reg && q_full);
    assign accept = start && !busy;

    assign in_view   = (7'(col) < 7'(cfg.cols)) && (7'(row) < 7'(cfg.rows));
    assign printable = (char_code >= ttcb_pkg::CODE_FIRST_PRINT)
                    && (char_code <= ttcb_pkg::CODE_LAST_PRINT);

    always_comb
    begin
        cmd_next.ch  = char_code;
        cmd_next.col = col;
        cmd_next.row = row;
        unique case (func)
            ttcb_pkg::FUNC_PUT_CHAR:
            begin
                if (char_code == ttcb_pkg::CODE_LF)
                begin
                    cmd_next.op = ttcb_pkg::OP_LF;
                end
                else if (char_code == ttcb_pkg::CODE_CR)
                begin
                    cmd_next.op = ttcb_pkg::OP_CR;
                end
                else if (printable)
                begin
                    cmd_next.op = ttcb_pkg::OP_PRINT;
                end
                else
                begin
                    cmd_next.op = ttcb_pkg::OP_NOP;
                end
            end
            ttcb_pkg::FUNC_WRITE_CHAR:
                cmd_next.op = in_view ? ttcb_pkg::OP_WRITE : ttcb_pkg::OP_NOP;
            ttcb_pkg::FUNC_LOCATE:
                cmd_next.op = in_view ? ttcb_pkg::OP_LOCATE : ttcb_pkg::OP_NOP;
            ttcb_pkg::FUNC_CLEAR:
                cmd_next.op = ttcb_pkg::OP_CLEAR;
            ttcb_pkg::FUNC_READ_CELL:
                cmd_next.op = in_view ? ttcb_pkg::OP_READ : ttcb_pkg::OP_NOP;
            default:
                cmd_next.op = ttcb_pkg::OP_NOP;
        endcase
    end

    assign cmd_valid_next = accept || (cmd_valid_reg && !push);
    assign push_cmd       = cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

@@ src/ttcb_back.sv @@
// Back end: executes classified commands against the character store and the cursor,
// runs the clear, scroll and power-up sweeps and drives the result beat.
// Depends on ttcb_pkg and ttcb_ram.
module ttcb_back #(
    parameter int MAX_COLS = ttcb_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = ttcb_pkg::DEF_MAX_ROWS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  ttcb_pkg::cmd_t     q_cmd,
    output logic               q_pop,
    input  ttcb_pkg::cfg_t     cfg,
    input  ttcb_pkg::cfg_upd_t cfg_upd,
    output logic               sweep_init,
    output logic               done,
    output ttcb_pkg::col_t     cursor_col,
    output ttcb_pkg::row_t     cursor_row,
    output logic               cell_written,
    output ttcb_pkg::col_t     written_col,
    output ttcb_pkg::row_t     written_row,
    output ttcb_pkg::char_t    written_char,
    output logic               scrolled,
    output logic               cleared,
    output ttcb_pkg::char_t    read_char
);

    localparam int CW          = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RW          = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int STORE_CELLS = MAX_COLS * MAX_ROWS;
    localparam int AW          = (STORE_CELLS > 1) ? $clog2(STORE_CELLS) : 1;
    localparam logic [AW-1:0] LAST_CELL = AW'(STORE_CELLS - 1);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_CLEAR,
        S_READ_WAIT,
        S_COPY,
        S_FILL
    } state_t;

    state_t          state_reg;
    state_t          state_next;
    logic [CW-1:0]   cur_x_reg;
    logic [CW-1:0]   cur_x_next;
    logic [RW-1:0]   cur_y_reg;
    logic [RW-1:0]   cur_y_next;
    logic [AW-1:0]   sweep_reg;
    logic [AW-1:0]   sweep_next;
    logic [CW-1:0]   sx_reg;
    logic [CW-1:0]   sx_next;
    logic [RW-1:0]   sy_reg;
    logic [RW-1:0]   sy_next;
    logic            cp_valid_reg;
    logic            cp_valid_next;
    logic [AW-1:0]   cp_addr_reg;
    logic [AW-1:0]   cp_addr_next;

    logic            done_reg;
    logic            done_next;
    ttcb_pkg::col_t  res_col_reg;
    ttcb_pkg::col_t  res_col_next;
    ttcb_pkg::row_t  res_row_reg;
    ttcb_pkg::row_t  res_row_next;
    logic            res_wr_reg;
    logic            res_wr_next;
    ttcb_pkg::col_t  res_wcol_reg;
    ttcb_pkg::col_t  res_wcol_next;
    ttcb_pkg::row_t  res_wrow_reg;
    ttcb_pkg::row_t  res_wrow_next;
    ttcb_pkg::char_t res_wch_reg;
    ttcb_pkg::char_t res_wch_next;
    logic            res_scr_reg;
    logic            res_scr_next;
    logic            res_clr_reg;
    logic            res_clr_next;
    ttcb_pkg::char_t res_rd_reg;
    ttcb_pkg::char_t res_rd_next;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    ttcb_pkg::char_t ram_wdata;
    logic [AW-1:0]   ram_raddr;
    ttcb_pkg::char_t ram_rdata;

    logic            x_wrap;
    logic            y_last;
    logic            sy_has_next;
    logic            line_feed;
    logic [CW-1:0]   last_col;
    logic [RW-1:0]   last_row;
    logic [CW-1:0]   cmd_x;
    logic [RW-1:0]   cmd_y;

    function automatic logic [AW-1:0] cell_addr(input logic [CW-1:0] x,
                                                input logic [RW-1:0] y);
        return AW'(y) * AW'(MAX_COLS) + AW'(x);
    endfunction

    ttcb_ram #(
        .WIDTH(ttcb_pkg::CHAR_W),
        .DEPTH(STORE_CELLS)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign x_wrap      = (8'(cur_x_reg) + 8'd1) >= 8'(cfg.cols);
    assign y_last      = (7'(cur_y_reg) + 7'd1) >= 7'(cfg.rows);
    assign sy_has_next = (7'(sy_reg) + 7'd1) < 7'(cfg.rows);
    assign last_col    = CW'(cfg.cols - 7'd1);
    assign last_row    = RW'(cfg.rows - 6'd1);
    assign cmd_x       = CW'(q_cmd.col);
    assign cmd_y       = RW'(q_cmd.row);

    always_comb
    begin
        state_next    = state_reg;
        cur_x_next    = cur_x_reg;
        cur_y_next    = cur_y_reg;
        sweep_next    = sweep_reg;
        sx_next       = sx_reg;
        sy_next       = sy_reg;
        cp_valid_next = cp_valid_reg;
        cp_addr_next  = cp_addr_reg;
        done_next     = 1'b0;
        res_col_next  = res_col_reg;
        res_row_next  = res_row_reg;
        res_wr_next   = res_wr_reg;
        res_wcol_next = res_wcol_reg;
        res_wrow_next = res_wrow_reg;
        res_wch_next  = res_wch_reg;
        res_scr_next  = res_scr_reg;
        res_clr_next  = res_clr_reg;
        res_rd_next   = res_rd_reg;
        q_pop         = 1'b0;
        line_feed     = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = ttcb_pkg::CODE_SPACE;
        ram_raddr     = '0;

        unique case (state_reg)
            S_INIT, S_CLEAR:
            begin
                // Fill every cell with a space, one address per cycle.
                ram_we    = 1'b1;
                ram_waddr = sweep_reg;
                if (sweep_reg == LAST_CELL)
                begin
                    state_next = S_IDLE;
                    done_next  = (state_reg == S_CLEAR);
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop         = 1'b1;
                    res_wr_next   = 1'b0;
                    res_wcol_next = '0;
                    res_wrow_next = '0;
                    res_wch_next  = '0;
                    res_scr_next  = 1'b0;
                    res_clr_next  = 1'b0;
                    res_rd_next   = '0;
                    unique case (q_cmd.op)
                        ttcb_pkg::OP_PRINT:
                        begin
                            ram_we        = 1'b1;
                            ram_waddr     = cell_addr(cur_x_reg, cur_y_reg);
                            ram_wdata     = q_cmd.ch;
                            res_wr_next   = 1'b1;
                            res_wcol_next = ttcb_pkg::col_t'(cur_x_reg);
                            res_wrow_next = ttcb_pkg::row_t'(cur_y_reg);
                            res_wch_next  = q_cmd.ch;
                            if (x_wrap)
                            begin
                                cur_x_next = '0;
                                line_feed  = 1'b1;
                            end
                            else
                            begin
                                cur_x_next = cur_x_reg + 1'b1;
                            end
                        end
                        ttcb_pkg::OP_LF:
                        begin
                            cur_x_next = '0;
                            line_feed  = 1'b1;
                        end
                        ttcb_pkg::OP_CR:
                        begin
                            cur_x_next = '0;
                        end
                        ttcb_pkg::OP_WRITE:
                        begin
                            ram_we        = 1'b1;
                            ram_waddr     = cell_addr(cmd_x, cmd_y);
                            ram_wdata     = q_cmd.ch;
                            res_wr_next   = 1'b1;
                            res_wcol_next = q_cmd.col;
                            res_wrow_next = q_cmd.row;
                            res_wch_next  = q_cmd.ch;
                        end
                        ttcb_pkg::OP_LOCATE:
                        begin
                            cur_x_next = cmd_x;
                            cur_y_next = cmd_y;
                        end
                        ttcb_pkg::OP_CLEAR:
                        begin
                            cur_x_next   = '0;
                            cur_y_next   = '0;
                            res_clr_next = 1'b1;
                            sweep_next   = '0;
                            state_next   = S_CLEAR;
                        end
                        ttcb_pkg::OP_READ:
                        begin
                            ram_raddr  = cell_addr(cmd_x, cmd_y);
                            state_next = S_READ_WAIT;
                        end
                        ttcb_pkg::OP_NOP:
                        begin
                        end
                    endcase
                    if (line_feed)
                    begin
                        if (y_last)
                        begin
                            // Cursor stays on the bottom row; the area scrolls up.
                            res_scr_next  = 1'b1;
                            sx_next       = '0;
                            sy_next       = '0;
                            cp_valid_next = 1'b0;
                            state_next    = S_COPY;
                        end
                        else
                        begin
                            cur_y_next = cur_y_reg + 1'b1;
                        end
                    end
                    res_col_next = ttcb_pkg::col_t'(cur_x_next);
                    res_row_next = ttcb_pkg::row_t'(cur_y_next);
                    done_next    = (state_next == S_IDLE);
                end
            end
            S_READ_WAIT:
            begin
                res_rd_next = ram_rdata;
                done_next   = 1'b1;
                state_next  = S_IDLE;
            end
            S_COPY:
            begin
                // Read the cell one row down; its data is written to the cell above in the next cycle.
                if (cp_valid_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = cp_addr_reg;
                    ram_wdata = ram_rdata;
                end
                if (sy_has_next)
                begin
                    ram_raddr     = cell_addr(sx_reg, RW'(sy_reg + 1'b1));
                    cp_valid_next = 1'b1;
                    cp_addr_next  = cell_addr(sx_reg, sy_reg);
                    if (sx_reg == last_col)
                    begin
                        sx_next = '0;
                        sy_next = sy_reg + 1'b1;
                    end
                    else
                    begin
                        sx_next = sx_reg + 1'b1;
                    end
                end
                else
                begin
                    cp_valid_next = 1'b0;
                    sx_next       = '0;
                    state_next    = S_FILL;
                end
            end
            S_FILL:
            begin
                ram_we    = 1'b1;
                ram_waddr = cell_addr(sx_reg, last_row);
                if (sx_reg == last_col)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    sx_next = sx_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A shrinking register write pulls the cursor back into the visible area.
        if (cfg_upd.we)
        begin
            if (8'(cur_x_reg) >= 8'(cfg_upd.cols))
            begin
                cur_x_next = CW'(cfg_upd.cols - 7'd1);
            end
            if (7'(cur_y_reg) >= 7'(cfg_upd.rows))
            begin
                cur_y_next = RW'(cfg_upd.rows - 6'd1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_INIT;
            cur_x_reg    <= '0;
            cur_y_reg    <= '0;
            sweep_reg    <= '0;
            sx_reg       <= '0;
            sy_reg       <= '0;
            cp_valid_reg <= 1'b0;
            cp_addr_reg  <= '0;
            done_reg     <= 1'b0;
            res_col_reg  <= '0;
            res_row_reg  <= '0;
            res_wr_reg   <= 1'b0;
            res_wcol_reg <= '0;
            res_wrow_reg <= '0;
            res_wch_reg  <= '0;
            res_scr_reg  <= 1'b0;
            res_clr_reg  <= 1'b0;
            res_rd_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            cur_x_reg    <= cur_x_next;
            cur_y_reg    <= cur_y_next;
            sweep_reg    <= sweep_next;
            sx_reg       <= sx_next;
            sy_reg       <= sy_next;
            cp_valid_reg <= cp_valid_next;
            cp_addr_reg  <= cp_addr_next;
            done_reg     <= done_next;
            res_col_reg  <= res_col_next;
            res_row_reg  <= res_row_next;
            res_wr_reg   <= res_wr_next;
            res_wcol_reg <= res_wcol_next;
            res_wrow_reg <= res_wrow_next;
            res_wch_reg  <= res_wch_next;
            res_scr_reg  <= res_scr_next;
            res_clr_reg  <= res_clr_next;
            res_rd_reg   <= res_rd_next;
        end
    end

    assign sweep_init   = (state_reg == S_INIT);
    assign done         = done_reg;
    assign cursor_col   = res_col_reg;
    assign cursor_row   = res_row_reg;
    assign cell_written = res_wr_reg;
    assign written_col  = res_wcol_reg;
    assign written_row  = res_wrow_reg;
    assign written_char = res_wch_reg;
    assign scrolled     = res_scr_reg;
    assign cleared      = res_clr_reg;
    assign read_char    = res_rd_reg;

    a_cursor_in_view: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |->
            (8'(cur_x_reg) < 8'(cfg.cols)) && (7'(cur_y_reg) < 7'(cfg.rows)))
        else $error("Cursor outside the visible area.");

    a_scroll_on_bottom: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && res_scr_reg |->
            res_row_reg == ttcb_pkg::row_t'(cfg.rows - 6'd1) && res_col_reg == '0)
        else $error("Scroll reported with the cursor off the start of the bottom row.");

    a_clear_after_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && res_clr_reg |->
            $past(state_reg) == S_CLEAR && res_col_reg == '0 && res_row_reg == '0)
        else $error("Clear reported without a finished clearing sweep.");

endmodule

@@ src/text_terminal_char_buffer.sv @@
// Top level of the text terminal character buffer: register port, front end, command
// queue and back end. Depends on ttcb_pkg, ttcb_front, ttcb_queue and ttcb_back.
//
// The block keeps a MAX_COLS x MAX_ROWS store of 8-bit characters (row stride MAX_COLS)
// and a cursor, and runs one command per beat on start/busy: put_char, write_char,
// locate, clear or read_cell. A command beat is taken at a rising edge with start high
// and busy low. Every command gives exactly one result beat, shown for one cycle with
// done high; the receiver cannot stall, so results must be taken as they come. The
// front end registers and classifies a command and hands it over a two-entry queue to
// the back end, so the front keeps taking beats while the back end sweeps the store,
// until the queue and the front register are full. From the accepting edge a command
// passes the front register, a queue slot and the back end's result registers before
// done; read_cell also waits for the registered memory read. A line feed on the bottom
// row scrolls the visible area, one cell per cycle through the single store port pair:
// every row but the last takes the row below, then the last row is filled with spaces.
// A clear writes every one of the MAX_COLS * MAX_ROWS cells, one per cycle (2048 cells
// at the default size). After reset the same clearing pass runs first; busy is high
// throughout it and no command is taken, while register writes are taken as ever.
// Back-to-back simple commands sustain one per cycle; otherwise the back end's sweeps
// set the rate. Registers sit on an APB-style port: columns_in_use at byte address 0
// and rows_in_use at byte address 4. Written values are saturated into 1..MAX_COLS and
// 1..MAX_ROWS, the cursor is pulled back into the new area, and they are meant to be
// written only while no command is in flight.
module text_terminal_char_buffer #(
    parameter int MAX_COLS = ttcb_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = ttcb_pkg::DEF_MAX_ROWS
) (
    input  logic                          clk,
    input  logic                          rst_n,

    // Command beat.
    input  logic                          start,
    output logic                          busy,
    input  ttcb_pkg::func_t               func,
    input  ttcb_pkg::char_t               char_code,
    input  ttcb_pkg::col_t                col,
    input  ttcb_pkg::row_t                row,

    // Result beat.
    output logic                          done,
    output ttcb_pkg::col_t                cursor_col,
    output ttcb_pkg::row_t                cursor_row,
    output logic                          cell_written,
    output ttcb_pkg::col_t                written_col,
    output ttcb_pkg::row_t                written_row,
    output ttcb_pkg::char_t               written_char,
    output logic                          scrolled,
    output logic                          cleared,
    output ttcb_pkg::char_t               read_char,

    // Register port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ttcb_pkg::PADDR_W-1:0]  paddr,
    input  logic [ttcb_pkg::PDATA_W-1:0]  pwdata,
    output logic [ttcb_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    // Reset values, kept inside the legal range of a small store.
    localparam int COLS_INIT = (ttcb_pkg::COLS_RESET > MAX_COLS) ? MAX_COLS
                                                                 : ttcb_pkg::COLS_RESET;
    localparam int ROWS_INIT = (ttcb_pkg::ROWS_RESET > MAX_ROWS) ? MAX_ROWS
                                                                 : ttcb_pkg::ROWS_RESET;

    ttcb_pkg::cols_cfg_t cols_reg;
    ttcb_pkg::cols_cfg_t cols_next;
    ttcb_pkg::rows_cfg_t rows_reg;
    ttcb_pkg::rows_cfg_t rows_next;
    ttcb_pkg::cols_cfg_t cols_wr;
    ttcb_pkg::rows_cfg_t rows_wr;
    ttcb_pkg::cols_cfg_t cols_sat;
    ttcb_pkg::rows_cfg_t rows_sat;
    logic                cfg_wr;
    ttcb_pkg::cfg_t      cfg;
    ttcb_pkg::cfg_upd_t  cfg_upd;

    logic                sweep_init;
    logic                q_push;
    ttcb_pkg::cmd_t      q_push_cmd;
    logic                q_full;
    logic                q_pop;
    ttcb_pkg::cmd_t      q_pop_cmd;
    logic                q_empty;

    // ------------------------------------------------------------------
    // Register port. pready is tied high: no access is ever extended by wait states.
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    assign cols_wr = pwdata[ttcb_pkg::COLS_CFG_W-1:0];
    assign rows_wr = pwdata[ttcb_pkg::ROWS_CFG_W-1:0];

    // Saturate written values into the range the store can hold.
    always_comb
    begin
        priority if (cols_wr == '0)
        begin
            cols_sat = ttcb_pkg::cols_cfg_t'(1);
        end
        else if (9'(cols_wr) > 9'(MAX_COLS))
        begin
            cols_sat = ttcb_pkg::cols_cfg_t'(MAX_COLS);
        end
        else
        begin
            cols_sat = cols_wr;
        end

        priority if (rows_wr == '0)
        begin
            rows_sat = ttcb_pkg::rows_cfg_t'(1);
        end
        else if (9'(rows_wr) > 9'(MAX_ROWS))
        begin
            rows_sat = ttcb_pkg::rows_cfg_t'(MAX_ROWS);
        end
        else
        begin
            rows_sat = rows_wr;
        end
    end

    always_comb
    begin
        cols_next = cols_reg;
        rows_next = rows_reg;
        if (cfg_wr)
        begin
            unique case (paddr[2])
                ttcb_pkg::REG_IDX_COLS: cols_next = cols_sat;
                ttcb_pkg::REG_IDX_ROWS: rows_next = rows_sat;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= ttcb_pkg::cols_cfg_t'(COLS_INIT);
            rows_reg <= ttcb_pkg::rows_cfg_t'(ROWS_INIT);
        end
        else
        begin
            cols_reg <= cols_next;
            rows_reg <= rows_next;
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            ttcb_pkg::REG_IDX_COLS: prdata = ttcb_pkg::PDATA_W'(cols_reg);
            ttcb_pkg::REG_IDX_ROWS: prdata = ttcb_pkg::PDATA_W'(rows_reg);
        endcase
    end

    assign cfg.cols     = cols_reg;
    assign cfg.rows     = rows_reg;
    assign cfg_upd.we   = cfg_wr;
    assign cfg_upd.cols = cols_next;
    assign cfg_upd.rows = rows_next;

    // ------------------------------------------------------------------
    // Front end, queue and back end.
    // ------------------------------------------------------------------
    ttcb_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .func     (func),
        .char_code(char_code),
        .col      (col),
        .row      (row),
        .cfg      (cfg),
        .hold     (sweep_init),
        .q_full   (q_full),
        .push     (q_push),
        .push_cmd (q_push_cmd)
    );

    ttcb_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_cmd(q_push_cmd),
        .full    (q_full),
        .pop     (q_pop),
        .pop_cmd (q_pop_cmd),
        .empty   (q_empty)
    );

    ttcb_back #(
        .MAX_COLS(MAX_COLS),
        .MAX_ROWS(MAX_ROWS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_cmd       (q_pop_cmd),
        .q_pop       (q_pop),
        .cfg         (cfg),
        .cfg_upd     (cfg_upd),
        .sweep_init  (sweep_init),
        .done        (done),
        .cursor_col  (cursor_col),
        .cursor_row  (cursor_row),
        .cell_written(cell_written),
        .written_col (written_col),
        .written_row (written_row),
        .written_char(written_char),
        .scrolled    (scrolled),
        .cleared     (cleared),
        .read_char   (read_char)
    );

endmodule
